/* rtl/core/x86enc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and register mapping functions of the x86 operand encoder.
package x86enc_pkg;

    // Operand kind selector.
    localparam logic [3:0] ACT_RM       = 4'd0;
    localparam logic [3:0] ACT_REG      = 4'd1;
    localparam logic [3:0] ACT_SEG      = 4'd2;
    localparam logic [3:0] ACT_CTRL     = 4'd3;
    localparam logic [3:0] ACT_DEBUG    = 4'd4;
    localparam logic [3:0] ACT_UIMM     = 4'd5;
    localparam logic [3:0] ACT_SIMM     = 4'd6;
    localparam logic [3:0] ACT_REL      = 4'd7;
    localparam logic [3:0] ACT_OFFSET   = 4'd8;
    localparam logic [3:0] ACT_FAR      = 4'd9;
    localparam logic [3:0] ACT_IMPLICIT = 4'd10;

    // Operand types.
    localparam logic [1:0] OT_REG = 2'd0;
    localparam logic [1:0] OT_MEM = 2'd1;
    localparam logic [1:0] OT_IMM = 2'd2;

    // Byte modes.
    localparam logic [2:0] BM_BYTE  = 3'd0;
    localparam logic [2:0] BM_WORD  = 3'd1;
    localparam logic [2:0] BM_DWORD = 3'd2;
    localparam logic [2:0] BM_VAR   = 3'd3;
    localparam logic [2:0] BM_FAR   = 3'd4;

    // Value kinds.
    localparam logic [1:0] VK_NONE = 2'd0;
    localparam logic [1:0] VK_IMM  = 2'd1;
    localparam logic [1:0] VK_DISP = 2'd2;
    localparam logic [1:0] VK_FAR  = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TYPE      = 3'd1;
    localparam logic [2:0] ERR_SIZE      = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_MODE      = 3'd4;
    localparam logic [2:0] ERR_ESP_INDEX = 3'd5;
    localparam logic [2:0] ERR_BAD_REG   = 3'd6;

    // Internal register numbers with a special meaning.
    localparam logic [3:0] REG_NONE = 4'd8;
    localparam logic [3:0] REG_ESP  = 4'd7;

    // ModRM / SIB codes used by the no-base and SIB forms.
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] RM_DISP32    = 3'd5;
    localparam logic [2:0] SIB_NO_INDEX = 3'd4;
    localparam logic [2:0] SIB_NO_BASE  = 3'd5;
    localparam logic [1:0] MOD_REG      = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  operand_type;
        logic [3:0]  base_reg;
        logic [3:0]  index_reg;
        logic [1:0]  scale_code;
        logic        high_byte;
        logic [2:0]  given_size;
        logic [31:0] raw_value;
        logic [2:0]  byte_mode;
        logic [15:0] selector_in;
    } op_in_t;

    typedef struct packed {
        logic [1:0]  mod_bits;
        logic [2:0]  reg_bits;
        logic [2:0]  rm_bits;
        logic [1:0]  sib_scale;
        logic [2:0]  sib_index;
        logic [2:0]  sib_base;
        logic        has_sib;
        logic [31:0] value;
        logic [2:0]  value_size;
        logic [1:0]  value_kind;
        logic [15:0] seg_selector;
        logic [2:0]  error_code;
    } op_out_t;

    // Internal order EAX,EBX,ECX,EDX,ESI,EDI,EBP,ESP mapped to hardware numbers.
    function automatic logic [2:0] gp_hw(input logic [2:0] r);
        logic [2:0] hw;
        unique case (r)
            3'd0: hw = 3'd0;
            3'd1: hw = 3'd3;
            3'd2: hw = 3'd1;
            3'd3: hw = 3'd2;
            3'd4: hw = 3'd6;
            3'd5: hw = 3'd7;
            3'd6: hw = 3'd5;
            default: hw = 3'd4;
        endcase
        return hw;
    endfunction

    // High-byte registers AH..DH.
    function automatic logic [2:0] hi_hw(input logic [1:0] r);
        logic [2:0] hw;
        unique case (r)
            2'd0: hw = 3'd4;
            2'd1: hw = 3'd7;
            2'd2: hw = 3'd5;
            default: hw = 3'd6;
        endcase
        return hw;
    endfunction

    // Segment order CS,DS,ES,FS,GS,SS; numbers above five are rejected earlier.
    function automatic logic [2:0] seg_hw(input logic [2:0] r);
        logic [2:0] hw;
        unique case (r)
            3'd0: hw = 3'd1;
            3'd1: hw = 3'd3;
            3'd2: hw = 3'd0;
            3'd3: hw = 3'd4;
            3'd4: hw = 3'd5;
            3'd5: hw = 3'd2;
            default: hw = 3'd0;
        endcase
        return hw;
    endfunction

endpackage

/* rtl/core/x86enc_logic.sv */
`timescale 1ns / 1ps
// Combinational encoding of one operand into ModRM, SIB, value and error fields.
module x86enc_logic (
    input  x86enc_pkg::op_in_t  op_i,
    output x86enc_pkg::op_out_t res_o
);
    import x86enc_pkg::*;

    always_comb begin
        op_out_t    r;
        logic [2:0] err;
        logic [2:0] sz;
        logic [31:0] v;
        logic       fit_u8, fit_u16, fit_s8, fit_s16;
        logic       is_uns, is_rel, fit_b, fit_w;
        logic [1:0] mod_sz;
        logic       sz_ok;

        r      = '0;
        err    = ERR_OK;
        sz     = op_i.given_size;
        v      = op_i.raw_value;
        fit_u8  = (v[31:8] == '0);
        fit_u16 = (v[31:16] == '0);
        fit_s8  = (v[31:7] == '0) || (v[31:7] == '1);
        fit_s16 = (v[31:15] == '0) || (v[31:15] == '1);
        is_uns = (op_i.action == ACT_UIMM);
        is_rel = (op_i.action == ACT_REL);
        fit_b  = is_uns ? fit_u8 : fit_s8;
        fit_w  = is_uns ? fit_u16 : fit_s16;

        // Displacement size to mod: none, disp8, disp32.
        sz_ok  = 1'b1;
        mod_sz = 2'd0;
        unique case (sz)
            3'd0: mod_sz = 2'd0;
            3'd1: mod_sz = 2'd1;
            3'd4: mod_sz = 2'd2;
            default: sz_ok = 1'b0;
        endcase

        unique case (op_i.action)
            ACT_RM: begin
                if (op_i.operand_type == OT_REG) begin
                    r.mod_bits = MOD_REG;
                    if (op_i.high_byte) begin
                        if (op_i.base_reg >= 4'd4) err = ERR_BAD_REG;
                        else r.rm_bits = hi_hw(op_i.base_reg[1:0]);
                    end else begin
                        if (op_i.base_reg >= 4'd8) err = ERR_BAD_REG;
                        else r.rm_bits = gp_hw(op_i.base_reg[2:0]);
                    end
                end else if (op_i.operand_type != OT_MEM) begin
                    err = ERR_TYPE;
                end else if (op_i.base_reg > REG_NONE || op_i.index_reg > REG_NONE) begin
                    err = ERR_BAD_REG;
                end else begin
                    if (op_i.index_reg != REG_NONE || op_i.base_reg == REG_ESP) begin
                        if (op_i.index_reg == REG_ESP) begin
                            err = ERR_ESP_INDEX;
                        end else begin
                            r.has_sib   = 1'b1;
                            r.rm_bits   = RM_SIB;
                            r.sib_index = (op_i.index_reg != REG_NONE)
                                          ? gp_hw(op_i.index_reg[2:0]) : SIB_NO_INDEX;
                            r.sib_scale = op_i.scale_code;
                            if (op_i.base_reg != REG_NONE) begin
                                r.sib_base = gp_hw(op_i.base_reg[2:0]);
                                r.mod_bits = mod_sz;
                                if (!sz_ok) err = ERR_SIZE;
                            end else begin
                                // No base: SIB base 5 with mod 0 means disp32 only.
                                if (sz != 3'd4) err = ERR_SIZE;
                                r.sib_base = SIB_NO_BASE;
                            end
                        end
                    end else if (op_i.base_reg == REG_NONE) begin
                        // Absolute address: mod 0, rm 5, disp32.
                        if (sz != 3'd4) err = ERR_SIZE;
                        r.rm_bits = RM_DISP32;
                    end else begin
                        r.rm_bits  = gp_hw(op_i.base_reg[2:0]);
                        r.mod_bits = mod_sz;
                        if (!sz_ok) err = ERR_SIZE;
                    end
                    if (sz != 3'd0) begin
                        r.value      = v;
                        r.value_size = sz;
                        r.value_kind = VK_DISP;
                    end
                end
            end
            ACT_REG: begin
                if (op_i.operand_type != OT_REG) begin
                    err = ERR_TYPE;
                end else if (op_i.high_byte) begin
                    if (op_i.base_reg >= 4'd4) err = ERR_BAD_REG;
                    else r.reg_bits = hi_hw(op_i.base_reg[1:0]);
                end else begin
                    if (op_i.base_reg >= 4'd8) err = ERR_BAD_REG;
                    else r.reg_bits = gp_hw(op_i.base_reg[2:0]);
                end
            end
            ACT_SEG: begin
                if (op_i.operand_type != OT_REG) err = ERR_TYPE;
                else if (op_i.base_reg >= 4'd6) err = ERR_BAD_REG;
                else r.reg_bits = seg_hw(op_i.base_reg[2:0]);
            end
            ACT_CTRL, ACT_DEBUG: begin
                if (op_i.base_reg >= 4'd8) err = ERR_BAD_REG;
                else r.reg_bits = op_i.base_reg[2:0];
            end
            ACT_UIMM, ACT_SIMM, ACT_REL: begin
                r.value      = v;
                r.value_kind = VK_IMM;
                if (!is_rel && op_i.operand_type != OT_IMM) begin
                    err = ERR_TYPE;
                end else if (op_i.byte_mode == BM_BYTE) begin
                    if (!fit_b) err = ERR_RANGE;
                    r.value_size = 3'd1;
                end else if (op_i.byte_mode == BM_WORD && !is_rel) begin
                    if (!fit_w) err = ERR_RANGE;
                    r.value_size = 3'd2;
                end else if (op_i.byte_mode == BM_DWORD && is_uns) begin
                    r.value_size = 3'd4;
                end else if (op_i.byte_mode == BM_VAR) begin
                    if (sz == 3'd2) begin
                        if (!fit_w) err = ERR_RANGE;
                        r.value_size = 3'd2;
                    end else if (sz == 3'd4) begin
                        r.value_size = 3'd4;
                    end else begin
                        err = ERR_SIZE;
                    end
                end else begin
                    err = ERR_MODE;
                end
            end
            ACT_OFFSET: begin
                if (op_i.operand_type != OT_MEM) err = ERR_TYPE;
                else if (op_i.base_reg != REG_NONE || op_i.index_reg != REG_NONE)
                    err = ERR_BAD_REG;
                else if (sz > 3'd4) err = ERR_SIZE;
                r.value      = v;
                r.value_size = sz;
                r.value_kind = VK_IMM;
            end
            ACT_FAR: begin
                if (op_i.byte_mode != BM_FAR) err = ERR_MODE;
                else if (sz > 3'd4) err = ERR_SIZE;
                r.value        = v;
                r.value_size   = sz;
                r.value_kind   = VK_FAR;
                r.seg_selector = op_i.selector_in;
            end
            default: begin
                // Implicit operands and unused selectors produce nothing.
                r = '0;
            end
        endcase

        // Any failed check clears every field but the error code.
        if (err != ERR_OK) begin
            r = '0;
        end
        r.error_code = err;
        res_o = r;
    end

endmodule

/* rtl/core/x86_operand_modrm_sib_encoder.sv */
`timescale 1ns / 1ps
// Top level of the x86 operand encoder: input register, encoding logic, result register.
//
//   Channel   Direction  Ports           Content
//   s_axis    in         tvalid/tready   one operand description per transfer
//   m_axis    out        tvalid/tready   one encoded operand per transfer
//
// Every input transfer yields exactly one output transfer: the operand is held
// in the input register, then passes through the encoder into the result
// register. The encoding logic is a few table lookups and compares, so a new
// operand is taken in every cycle while m_axis is not stalled.
// A stall on m_axis backs up through the two stages; s_axis_tready only drops
// when both stages are full. Reset (aresetn low, synchronous) empties both
// stages; payload registers are not reset.
module x86_operand_modrm_sib_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // base_reg[3:0], index_reg[7:4], scale_code[9:8], high_byte[10],
    // given_size[13:11], raw_value[45:14], byte_mode[48:46],
    // selector_in[64:49], zero pad [71:65]
    input  logic [71:0] s_axis_tdata,
    // action[3:0], operand_type[5:4]
    input  logic [5:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mod_bits[1:0], reg_bits[4:2], rm_bits[7:5], sib_scale[9:8],
    // sib_index[12:10], sib_base[15:13], has_sib[16], value[48:17],
    // value_size[51:49], seg_selector[67:52], error_code[70:68], zero pad [71]
    output logic [71:0] m_axis_tdata,
    // value_kind[1:0]
    output logic [1:0]  m_axis_tuser
);
    import x86enc_pkg::*;

    op_in_t  in_reg;
    op_in_t  in_next;
    logic    in_valid_reg;
    op_out_t res_reg;
    op_out_t res_next;
    logic    res_valid_reg;

    logic    res_free;
    logic    in_free;

    // The result stage can take a new value when empty or being drained.
    assign res_free      = !res_valid_reg || m_axis_tready;
    assign in_free       = !in_valid_reg || res_free;
    assign s_axis_tready = in_free;

    always_comb begin
        in_next.action       = s_axis_tuser[3:0];
        in_next.operand_type = s_axis_tuser[5:4];
        in_next.base_reg     = s_axis_tdata[3:0];
        in_next.index_reg    = s_axis_tdata[7:4];
        in_next.scale_code   = s_axis_tdata[9:8];
        in_next.high_byte    = s_axis_tdata[10];
        in_next.given_size   = s_axis_tdata[13:11];
        in_next.raw_value    = s_axis_tdata[45:14];
        in_next.byte_mode    = s_axis_tdata[48:46];
        in_next.selector_in  = s_axis_tdata[64:49];
    end

    x86enc_logic u_enc (
        .op_i  (in_reg),
        .res_o (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (res_free) begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_axis_tvalid) begin
            in_reg <= in_next;
        end
        if (res_free && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_reg.value_kind;
    assign m_axis_tdata  = {1'b0,
                            res_reg.error_code,
                            res_reg.seg_selector,
                            res_reg.value_size,
                            res_reg.value,
                            res_reg.has_sib,
                            res_reg.sib_base,
                            res_reg.sib_index,
                            res_reg.sib_scale,
                            res_reg.rm_bits,
                            res_reg.reg_bits,
                            res_reg.mod_bits};

endmodule
